// ----- hw/rtl/tns_pkg.sv -----
// Shared types, codes and helpers for the texture nearest sampler.
package tns_pkg;

	localparam int MAX_DIM = 2048;
	localparam int FRAC_BITS = 16;
	localparam int DIM_W = 12;

	typedef enum logic [1:0] {
		KIND_REQ   = 2'd0,
		KIND_COLOR = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_FORMAT = 2'd1,
		ERR_READ   = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		FMT_RGBA8  = 3'd0,
		FMT_ARGB8  = 3'd1,
		FMT_XRGB8  = 3'd2,
		FMT_RGB565 = 3'd3
	} fmt_t;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_FORMAT = 3'd1,
		REG_LAYOUT = 3'd2,
		REG_WRAP   = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5,
		REG_PITCH  = 3'd6,
		REG_BASE   = 3'd7
	} reg_t;

	typedef struct packed {
		logic        enable;
		logic [2:0]  format;
		logic        layout;
		logic [1:0]  wrap;
		logic [11:0] width;
		logic [11:0] height;
		logic [31:0] pitch;
		logic [31:0] base;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic [1:0]  err;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load_coord;
		logic scale;
		logic addr_mul;
		logic addr_sum;
		logic gather;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic        last;
		logic [31:0] next_addr;
		logic [31:0] bytes;
	} sts_t;

	function automatic logic [11:0] eff_size(input logic [11:0] s);
		if (s == 12'd0) return 12'd1;
		if (s > 12'(MAX_DIM)) return 12'(MAX_DIM);
		return s;
	endfunction

	// v * 255 / 31, truncated, by reciprocal multiplication
	function automatic logic [7:0] exp5(input logic [4:0] v);
		logic [12:0] x;
		logic [28:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = 29'(x) * 29'd33826;
		return p[27:20];
	endfunction

	// v * 255 / 63, truncated, by reciprocal multiplication
	function automatic logic [7:0] exp6(input logic [5:0] v);
		logic [13:0] x;
		logic [29:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = 30'(x) * 30'd16645;
		return p[27:20];
	endfunction

endpackage

// ----- hw/rtl/tns_datapath.sv -----
// Coordinate, address and byte gather datapath of the texture sampler.
module tns_datapath import tns_pkg::*; (
	input  logic        clk,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	input  logic [31:0] coord_u,
	input  logic [31:0] coord_v,
	input  logic [31:0] read_word,
	output sts_t        sts,
	output logic [31:0] addr
);

	logic [16:0] nu_q, nv_q;
	logic [11:0] tx_q, ty_q, w_q, h_q;
	logic [31:0] rowoff_q, addr_q;
	logic [23:0] morton_q;
	logic [2:0]  left_q, got_q;
	logic [31:0] bytes_q;
	logic [16:0] nu, nv;
	logic [28:0] pu, pv;
	logic [16:0] tu, tv;
	logic [23:0] mort;
	logic [11:0] wm, hm;
	logic [4:0]  pos;
	logic [1:0]  off;
	logic [2:0]  take, room, got;
	logic [31:0] bts;
	logic        bpp2;

	function automatic logic [16:0] norm(input logic [31:0] c, input logic clamp);
		if (!clamp) return {1'b0, c[15:0]};
		if (c[31]) return 17'd0;
		if (c[30:16] != 15'd0 && !(c[30:16] == 15'd1 && c[15:0] == 16'd0)) return 17'h10000;
		return c[16:0];
	endfunction

	assign nu = norm(coord_u, cfg.wrap[0]);
	assign nv = norm(coord_v, cfg.wrap[1]);
	assign pu = nu_q * w_q;
	assign pv = nv_q * h_q;
	assign tu = pu[28:12] >> 4;
	assign tv = pv[28:12] >> 4;
	assign bpp2 = (cfg.format == FMT_RGB565);

	always_comb begin
		mort = '0;
		wm = w_q;
		hm = h_q;
		pos = '0;
		for (int i = 0; i < 12; i++) begin
			if (wm > 12'd1) begin
				mort[pos] = tx_q[i];
				pos = pos + 5'd1;
				wm = wm >> 1;
			end
			if (hm > 12'd1) begin
				mort[pos] = ty_q[i];
				pos = pos + 5'd1;
				hm = hm >> 1;
			end
		end
	end

	always_comb begin
		off = addr_q[1:0];
		room = 3'd4 - {1'b0, off};
		take = (room > left_q) ? left_q : room;
		bts = bytes_q;
		got = got_q;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < take) begin
				if (got < 3'd4) bts[got[1:0]*8 +: 8] = read_word[(2'(k) + off)*8 +: 8];
				got = got + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_coord) begin
			nu_q <= nu;
			nv_q <= nv;
			w_q <= eff_size(cfg.width);
			h_q <= eff_size(cfg.height);
		end
		if (cmd.scale) begin
			tx_q <= (tu >= {5'd0, w_q}) ? w_q - 12'd1 : tu[11:0];
			ty_q <= (tv >= {5'd0, h_q}) ? h_q - 12'd1 : tv[11:0];
		end
		if (cmd.addr_mul) begin
			rowoff_q <= cfg.pitch * {20'd0, ty_q};
			morton_q <= mort;
		end
		if (cmd.addr_sum) begin
			if (cfg.layout)
				addr_q <= cfg.base + ({8'd0, morton_q} << (bpp2 ? 1 : 2));
			else
				addr_q <= cfg.base + rowoff_q + ({20'd0, tx_q} << (bpp2 ? 1 : 2));
			left_q <= bpp2 ? 3'd2 : 3'd4;
			got_q <= '0;
			bytes_q <= '0;
		end
		if (cmd.gather) begin
			bytes_q <= bts;
			got_q <= got;
			left_q <= left_q - take;
			addr_q <= addr_q + {29'd0, take};
		end
	end

	assign addr = addr_q;
	assign sts.last = (left_q == take);
	assign sts.next_addr = addr_q + {29'd0, take};
	assign sts.bytes = bts;

endmodule

// ----- hw/rtl/tns_ctrl.sv -----
// Sequencing state machine and result register of the texture sampler.
module tns_ctrl import tns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_acc,
	input  logic        mode,
	input  logic        read_failed,
	input  sts_t        sts,
	input  logic [31:0] addr,
	input  logic        out_take,
	output cmd_t        cmd,
	output logic        busy,
	output logic        out_valid,
	output res_t        res
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCALE, S_MUL, S_SUM, S_ISSUE, S_WAIT
	} state_t;

	state_t state_q;
	logic   valid_q;
	res_t   res_q, color;
	logic [15:0] px;

	function automatic res_t mk_res(input logic [1:0] k, input logic [31:0] a,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] al, input logic [1:0] e);
		res_t x;
		x.kind = k;
		x.addr = a;
		x.r = r;
		x.g = g;
		x.b = b;
		x.a = al;
		x.err = e;
		return x;
	endfunction

	assign px = sts.bytes[15:0];

	always_comb begin
		color = '0;
		color.kind = KIND_COLOR;
		case (cfg.format)
			FMT_RGBA8: begin
				color.r = sts.bytes[7:0]; color.g = sts.bytes[15:8];
				color.b = sts.bytes[23:16]; color.a = sts.bytes[31:24];
			end
			FMT_ARGB8: begin
				color.r = sts.bytes[23:16]; color.g = sts.bytes[15:8];
				color.b = sts.bytes[7:0]; color.a = sts.bytes[31:24];
			end
			FMT_XRGB8: begin
				color.r = sts.bytes[23:16]; color.g = sts.bytes[15:8];
				color.b = sts.bytes[7:0]; color.a = 8'hFF;
			end
			FMT_RGB565: begin
				color.r = exp5(px[15:11]); color.g = exp6(px[10:5]);
				color.b = exp5(px[4:0]); color.a = 8'hFF;
			end
			default: begin
				color.kind = KIND_ERR;
				color.err = ERR_FORMAT;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load_coord = in_acc && !mode;
		cmd.scale = (state_q == S_SCALE);
		cmd.addr_mul = (state_q == S_MUL);
		cmd.addr_sum = (state_q == S_SUM);
		cmd.gather = in_acc && mode && (state_q == S_WAIT) && !read_failed;
	end

	assign busy = (state_q != S_IDLE && state_q != S_WAIT) || valid_q;
	assign out_valid = valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (out_take) valid_q <= 1'b0;
			case (state_q)
				S_SCALE: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_ISSUE;
				S_ISSUE: begin
					res_q <= mk_res(KIND_REQ, {addr[31:2], 2'b00}, 8'd0, 8'd0, 8'd0, 8'd0,
						ERR_NONE);
					valid_q <= 1'b1;
					state_q <= S_WAIT;
				end
				default: ;
			endcase
			if (in_acc) begin
				if (!mode) begin
					if (!cfg.enable) begin
						res_q <= mk_res(KIND_COLOR, 32'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
							ERR_NONE);
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (cfg.format > FMT_RGB565) begin
						res_q <= mk_res(KIND_ERR, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, ERR_FORMAT);
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCALE;
					end
				end else if (state_q == S_WAIT) begin
					valid_q <= 1'b1;
					if (read_failed) begin
						res_q <= mk_res(KIND_ERR, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, ERR_READ);
						state_q <= S_IDLE;
					end else if (sts.last) begin
						res_q <= color;
						state_q <= S_IDLE;
					end else begin
						res_q <= mk_res(KIND_REQ, {sts.next_addr[31:2], 2'b00}, 8'd0, 8'd0,
							8'd0, 8'd0, ERR_NONE);
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/texture_nearest_sampler.sv -----
// Top level of the nearest-neighbor texture sampler.
// From acceptance a sample request runs the coordinate scale multiply,
// pitch multiply, address add and issue states up to its read request; a
// disabled sampler or bad format answers in the cycle after acceptance, as
// does each read response. One item is handled at a time, and the input
// stalls only while the result register is full or the address chain runs.
module texture_nearest_sampler import tns_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // coord_u, coord_v, read_word, read_failed, pad
	input  logic         s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // request_address, red, green, blue, alpha, error_code, pad
	output logic [1:0]   m_tuser,  // result_kind
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	res_t res;
	logic busy, in_acc, out_take;
	logic [31:0] addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{enable: 1'b0, format: 3'd0, layout: 1'b0, wrap: 2'd0,
				width: 12'd1, height: 12'd1, pitch: 32'd0, base: 32'd0};
		end else if (cfg_we) begin
			case (reg_t'(cfg_index))
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_FORMAT: cfg_q.format <= cfg_data[2:0];
				REG_LAYOUT: cfg_q.layout <= cfg_data[0];
				REG_WRAP:   cfg_q.wrap <= cfg_data[1:0];
				REG_WIDTH:  cfg_q.width <= cfg_data[11:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[11:0];
				REG_PITCH:  cfg_q.pitch <= cfg_data;
				REG_BASE:   cfg_q.base <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_take = m_tvalid && m_tready;
	assign s_tready = !busy;
	assign in_acc = s_tvalid && s_tready;

	tns_datapath u_dp (
		.clk(clk), .cfg(cfg_q), .cmd(cmd),
		.coord_u(s_tdata[31:0]), .coord_v(s_tdata[63:32]),
		.read_word(s_tdata[95:64]), .sts(sts), .addr(addr)
	);

	tns_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_acc(in_acc),
		.mode(s_tuser), .read_failed(s_tdata[96]), .sts(sts), .addr(addr),
		.out_take(out_take), .cmd(cmd), .busy(busy), .out_valid(m_tvalid),
		.res(res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {6'd0, res.err, res.a, res.b, res.g, res.r, res.addr};

	a_no_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready) else $error("accept while result held");
	a_req_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_REQ) |-> (m_tdata[1:0] == 2'b00))
		else $error("unaligned request");
	a_color_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_COLOR) |-> (m_tdata[65:64] == ERR_NONE))
		else $error("color with error code");

endmodule

// ----- test/tex_sample_checker.sv -----
`timescale 1ns / 1ps
// Checker for the texture nearest sampler: predicts each result and compares it.
module tex_sample_checker import tns_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,  // coord_u, coord_v, read_word, read_failed, pad
	input  logic         s_tuser,  // mode
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,  // request_address, red, green, blue, alpha, error_code, pad
	input  logic [1:0]   m_tuser,  // result_kind
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           colors_seen,
	output int           faults_seen
);

	cfg_t cfg;
	logic        busy;
	logic [31:0] byte_addr;
	logic [2:0]  left_cnt;
	logic [2:0]  got_cnt;
	logic [31:0] gathered;
	res_t        sample_q[$];

	function automatic logic [11:0] size_of(input logic [11:0] s);
		if (s == 12'd0) return 12'd1;
		if (s > 12'(MAX_DIM)) return 12'(MAX_DIM);
		return s;
	endfunction

	function automatic logic [31:0] texel_pos(input logic [31:0] raw, input logic clamp,
			input logic [11:0] size);
		logic [63:0] norm;
		logic [63:0] t;
		if (clamp) begin
			if (raw[31]) norm = 0;
			else if (raw > 32'h0001_0000) norm = 64'h0001_0000;
			else norm = {32'd0, raw};
		end else begin
			norm = {48'd0, raw[15:0]};
		end
		t = (norm * size) >> FRAC_BITS;
		if (t >= size) t = size - 1;
		return t[31:0];
	endfunction

	function automatic logic [31:0] morton(input logic [31:0] x, input logic [31:0] y,
			input logic [11:0] w_in, input logic [11:0] h_in);
		logic [31:0] idx;
		int pos;
		int b;
		logic [11:0] w;
		logic [11:0] h;
		idx = 0;
		pos = 0;
		b = 0;
		w = w_in;
		h = h_in;
		while ((w > 1 || h > 1) && b < 32) begin
			if (w > 1) begin
				if (pos < 32 && x[b]) idx[pos] = 1'b1;
				pos++;
				w = w >> 1;
			end
			if (h > 1) begin
				if (pos < 32 && y[b]) idx[pos] = 1'b1;
				pos++;
				h = h >> 1;
			end
			b++;
		end
		return idx;
	endfunction

	function automatic res_t make_res(input kind_t k, input logic [31:0] a, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] al, input err_t e);
		res_t x;
		x.kind = k;
		x.addr = a;
		x.r = r;
		x.g = g;
		x.b = b;
		x.a = al;
		x.err = e;
		return x;
	endfunction

	task automatic predict_sample(input logic mode, input logic [31:0] u, input logic [31:0] v,
			input logic [31:0] word, input logic failed);
		logic [11:0] w;
		logic [11:0] h;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] bpp;
		logic [31:0] addr;
		logic [31:0] off;
		logic [31:0] take;
		logic [15:0] px;
		logic [7:0]  bt[4];
		if (!mode) begin
			busy = 1'b0;
			if (!cfg.enable) begin
				sample_q.push_back(make_res(KIND_COLOR, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ERR_NONE));
				return;
			end
			if (cfg.format > FMT_RGB565) begin
				sample_q.push_back(make_res(KIND_ERR, 0, 0, 0, 0, 0, ERR_FORMAT));
				return;
			end
			bpp = (cfg.format == FMT_RGB565) ? 2 : 4;
			w = size_of(cfg.width);
			h = size_of(cfg.height);
			tx = texel_pos(u, cfg.wrap[0], w);
			ty = texel_pos(v, cfg.wrap[1], h);
			if (!cfg.layout) addr = cfg.base + ty * cfg.pitch + tx * bpp;
			else addr = cfg.base + morton(tx, ty, w, h) * bpp;
			busy = 1'b1;
			byte_addr = addr;
			left_cnt = bpp[2:0];
			got_cnt = 0;
			gathered = 0;
			sample_q.push_back(make_res(KIND_REQ, {addr[31:2], 2'b00}, 0, 0, 0, 0, ERR_NONE));
			return;
		end
		if (!busy) return;
		if (failed) begin
			busy = 1'b0;
			sample_q.push_back(make_res(KIND_ERR, 0, 0, 0, 0, 0, ERR_READ));
			return;
		end
		off = {30'd0, byte_addr[1:0]};
		take = 4 - off;
		if (take > left_cnt) take = left_cnt;
		for (int k = 0; k < take; k++) begin
			if (got_cnt < 4) gathered[got_cnt*8 +: 8] = word[(off + k)*8 +: 8];
			got_cnt = got_cnt + 1;
		end
		left_cnt = left_cnt - take[2:0];
		byte_addr = byte_addr + take;
		if (left_cnt != 0) begin
			sample_q.push_back(make_res(KIND_REQ, {byte_addr[31:2], 2'b00}, 0, 0, 0, 0,
				ERR_NONE));
			return;
		end
		busy = 1'b0;
		for (int k = 0; k < 4; k++) bt[k] = gathered[k*8 +: 8];
		px = {bt[1], bt[0]};
		case (cfg.format)
			FMT_RGBA8: sample_q.push_back(make_res(KIND_COLOR, 0, bt[0], bt[1], bt[2], bt[3],
				ERR_NONE));
			FMT_ARGB8: sample_q.push_back(make_res(KIND_COLOR, 0, bt[2], bt[1], bt[0], bt[3],
				ERR_NONE));
			FMT_XRGB8: sample_q.push_back(make_res(KIND_COLOR, 0, bt[2], bt[1], bt[0], 8'hFF,
				ERR_NONE));
			FMT_RGB565: sample_q.push_back(make_res(KIND_COLOR, 0,
				8'(32'(px[15:11]) * 255 / 31), 8'(32'(px[10:5]) * 255 / 63),
				8'(32'(px[4:0]) * 255 / 31), 8'hFF, ERR_NONE));
			default: sample_q.push_back(make_res(KIND_ERR, 0, 0, 0, 0, 0, ERR_FORMAT));
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '0;
			cfg.width = 12'd1;
			cfg.height = 12'd1;
			busy = 0;
			byte_addr = 0;
			left_cnt = 0;
			got_cnt = 0;
			gathered = 0;
			sample_q.delete();
			errors = 0;
			colors_seen = 0;
			faults_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sample_q.size() == 0) begin
					report("unexpected item kind", {30'd0, m_tuser}, 0);
				end else begin
					res_t want;
					want = sample_q.pop_front();
					if (m_tuser != want.kind) report("kind", {30'd0, m_tuser}, {30'd0, want.kind});
					if (m_tdata[31:0] != want.addr) report("address", m_tdata[31:0], want.addr);
					if (m_tdata[39:32] != want.r) report("red", m_tdata[39:32], want.r);
					if (m_tdata[47:40] != want.g) report("green", m_tdata[47:40], want.g);
					if (m_tdata[55:48] != want.b) report("blue", m_tdata[55:48], want.b);
					if (m_tdata[63:56] != want.a) report("alpha", m_tdata[63:56], want.a);
					if (m_tdata[65:64] != want.err) report("error", m_tdata[65:64], want.err);
					if (want.kind == KIND_COLOR) colors_seen++;
					if (want.kind == KIND_ERR) faults_seen++;
				end
			end
			if (s_tvalid && s_tready)
				predict_sample(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
					s_tdata[96]);
			if (cfg_we) begin
				case (reg_t'(cfg_index))
					REG_ENABLE: cfg.enable = cfg_data[0];
					REG_FORMAT: cfg.format = cfg_data[2:0];
					REG_LAYOUT: cfg.layout = cfg_data[0];
					REG_WRAP:   cfg.wrap = cfg_data[1:0];
					REG_WIDTH:  cfg.width = cfg_data[11:0];
					REG_HEIGHT: cfg.height = cfg_data[11:0];
					REG_PITCH:  cfg.pitch = cfg_data;
					REG_BASE:   cfg.base = cfg_data;
					default: ;
				endcase
			end
		end
		pending = sample_q.size();
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the texture nearest sampler: stimulus, configuration and verdict.
module tb;
	import tns_pkg::*;

	localparam int NUM_PHASES = 16;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;  // coord_u, coord_v, read_word, read_failed, pad
	logic         s_tuser;  // mode
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;  // request_address, red, green, blue, alpha, error_code, pad
	logic [1:0]   m_tuser;  // result_kind
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	int errors;
	int pending;
	int colors_seen;
	int faults_seen;
	int cycles;
	int sent;
	int burst_left;

	texture_nearest_sampler DUT (.*);

	tex_sample_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("texture_nearest_sampler verification failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off while the sender keeps offering
	initial begin
		int n;
		m_tready = 0;
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n >= 3000 && n < 3400) m_tready <= 1'b0;
			else if ((n / 200) % 3 == 0) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_item(input logic mode, input logic [31:0] u, input logic [31:0] v,
			input logic [31:0] word, input logic failed);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'd0, failed, word, v, u};
		do @(posedge clk); while (!s_tready);
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
	endtask

	task automatic write_reg(input reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic settle;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_phase(input int p);
		logic        en;
		logic [2:0]  fmt;
		logic        lay;
		logic [1:0]  wrp;
		logic [11:0] w;
		logic [11:0] h;
		logic [31:0] pitch;
		logic [31:0] base;
		en = 1;
		fmt = FMT_RGBA8;
		lay = 0;
		wrp = 0;
		w = 16;
		h = 16;
		pitch = 64;
		base = 32'h1000;
		case (p)
			0: ;
			1: en = 0;
			2: begin
				fmt = FMT_ARGB8; wrp = 3; w = 2048; h = 2048; pitch = '1; base = '1;
			end
			3: begin
				fmt = FMT_XRGB8; lay = 1; w = 12'hFFF; h = 0; base = 3;
			end
			4: begin
				fmt = FMT_RGB565; lay = 1; wrp = 1; w = 13; h = 7; base = 1;
			end
			5: fmt = 3'd5;
			6: fmt = 3'd7;
			7: begin
				fmt = FMT_RGB565; wrp = 2; base = 3; pitch = 6;
			end
			default: begin
				en = ($urandom_range(0, 7) != 0);
				fmt = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7))
					: 3'($urandom_range(0, 3));
				lay = $urandom_range(0, 1);
				wrp = $urandom_range(0, 3);
				w = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1, 64));
				h = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1, 64));
				pitch = $urandom;
				base = $urandom;
			end
		endcase
		write_reg(REG_ENABLE, {31'd0, en});
		write_reg(REG_FORMAT, {29'd0, fmt});
		write_reg(REG_LAYOUT, {31'd0, lay});
		write_reg(REG_WRAP, {30'd0, wrp});
		write_reg(REG_WIDTH, {20'd0, w});
		write_reg(REG_HEIGHT, {20'd0, h});
		write_reg(REG_PITCH, pitch);
		write_reg(REG_BASE, base);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
		endcase
	endfunction

	task automatic sample_sequence;
		int r;
		r = $urandom_range(0, 9);
		if (r <= 6) begin
			send_item(0, rand_coord(), rand_coord(), $urandom, 0);
			send_item(1, $urandom, $urandom, $urandom, $urandom_range(0, 15) == 0);
			send_item(1, $urandom, $urandom, $urandom, $urandom_range(0, 15) == 0);
		end else if (r == 7) begin
			send_item(1, $urandom, $urandom, $urandom, $urandom_range(0, 1));
		end else begin
			send_item(0, rand_coord(), rand_coord(), $urandom, $urandom_range(0, 1));
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		cfg_we = 0;
		cfg_index = REG_ENABLE;
		cfg_data = 0;
		sent = 0;
		burst_left = 5;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_phase(p);
			if (p == 0) begin
				send_item(1, 0, 0, 32'h1234_5678, 0);
				send_item(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
				send_item(1, 0, 0, 32'hFFFF_FFFF, 0);
				send_item(0, 32'h0001_0000, 32'h0000_FFFF, 0, 0);
				send_item(1, 0, 0, 32'h0000_0000, 1);
				send_item(0, 0, 0, 0, 0);
				send_item(0, 32'hFFFF_FFFF, 32'h0000_8000, 0, 0);
				send_item(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5C3_0F81, 0);
			end
			while (sent < (p + 1) * ITEMS_PER_PHASE) sample_sequence();
			settle();
		end
		$display("Sent %0d items over %0d register settings.", sent, NUM_PHASES);
		$display("Checked %0d colors and %0d error answers.", colors_seen, faults_seen);
		if (errors == 0) begin
			$display("texture_nearest_sampler verification clean");
		end else begin
			$display("texture_nearest_sampler verification failed");
		end
		$finish;
	end

endmodule
